@@ hw/rtl/line_to_2bpp_pixel_writer_unit_defines.svh @@
// Assertion macros shared by the line pixel writer modules.
`ifndef LINE_TO_2BPP_PIXEL_WRITER_UNIT_DEFINES_SVH
`define LINE_TO_2BPP_PIXEL_WRITER_UNIT_DEFINES_SVH

// Property checked on every rising edge, off while reset is asserted.
`define L2P_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen.
`define L2P_NEVER(label, clk, rst_n, expr, msg) \
    `L2P_ASSERT(label, clk, rst_n, !(expr), msg)

`endif

@@ hw/rtl/l2p_pkg.sv @@
// Shared constants and types of the line pixel writer.
`default_nettype none

package l2p_pkg;

    localparam int LW_BITS    = 12;
    localparam int FW_BITS    = 17;
    localparam int WORD_BITS  = 16;
    localparam int OFF_BITS   = 5;
    localparam int COLOR_BITS = 2;
    localparam int CFG_IDX_BITS = 1;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    localparam logic [CFG_IDX_BITS-1:0] CFG_LINE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_WORDS = 1'b1;

    localparam logic [LW_BITS-1:0] LINE_WIDTH_RST  = 12'd640;
    localparam logic [FW_BITS-1:0] FRAME_WORDS_RST = 17'd19200;

    // the frame is capped at 2^16 words, so word_index stays below 2^16
    localparam logic [FW_BITS-1:0] FRAME_CAP = 17'h10000;

    typedef struct packed {
        logic [LW_BITS-1:0] line_width;
        logic [FW_BITS-1:0] frame_words;
    } t_cfg;

endpackage

`default_nettype wire

@@ hw/rtl/l2p_fifo.sv @@
// Small register queue between the line stepper and the address unit.
`default_nettype none
`include "line_to_2bpp_pixel_writer_unit_defines.svh"

module l2p_fifo #(
    parameter int WIDTH = 27,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_valid,
    output logic [WIDTH-1:0]      o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_do_pop;

    assign o_full   = (r_count == CNT_FULL);
    assign o_valid  = (r_count != '0);
    assign o_data   = r_mem[r_rd_ptr];
    assign w_do_pop = i_pop & o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !w_do_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && w_do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    `L2P_NEVER(a_fifo_overflow, i_clk, i_rst_n, i_push && o_full, "push into full queue")
    `L2P_ASSERT(a_fifo_count, i_clk, i_rst_n, r_count <= CNT_FULL, "queue count out of range")

endmodule

`default_nettype wire

@@ hw/rtl/l2p_front.sv @@
// Command front end: Bresenham stepper that emits one point per start command and per step while a line is active.
`default_nettype none
`include "line_to_2bpp_pixel_writer_unit_defines.svh"

module l2p_front #(
    parameter int COORD_BITS = 12
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic                         i_cmd,
    input  wire logic signed [COORD_BITS-1:0] i_start_x,
    input  wire logic signed [COORD_BITS-1:0] i_start_y,
    input  wire logic signed [COORD_BITS-1:0] i_end_x,
    input  wire logic signed [COORD_BITS-1:0] i_end_y,
    input  wire logic [l2p_pkg::COLOR_BITS-1:0] i_pen_color,
    input  wire logic                         i_q_full,
    output logic                              o_q_push,
    output logic [2*COORD_BITS+l2p_pkg::COLOR_BITS:0] o_q_data
);

    localparam int C = COORD_BITS;

    logic signed [C-1:0] r_cur_x, n_cur_x;
    logic signed [C-1:0] r_cur_y, n_cur_y;
    logic signed [C-1:0] r_tgt_x, n_tgt_x;
    logic signed [C-1:0] r_tgt_y, n_tgt_y;
    logic signed [C:0]   r_dx, n_dx;
    logic signed [C:0]   r_ndy, n_ndy;
    logic                r_sx_neg, n_sx_neg;
    logic                r_sy_neg, n_sy_neg;
    logic signed [C+2:0] r_err, n_err;
    logic [l2p_pkg::COLOR_BITS-1:0] r_color, n_color;
    logic                r_active, n_active;

    logic                w_accept;
    logic                w_start;
    logic signed [C:0]   w_raw_x;
    logic signed [C:0]   w_raw_y;
    logic signed [C+3:0] w_e2;
    logic signed [C+3:0] w_ndy_e;
    logic signed [C+3:0] w_dx_e;
    logic                w_move_x;
    logic                w_move_y;
    logic                w_at_end;

    assign o_stall  = i_q_full;
    assign w_accept = i_valid & ~i_q_full;
    assign w_start  = (i_cmd == l2p_pkg::CMD_START);
    assign o_q_push = w_accept & (w_start | r_active);
    assign o_q_data = {n_cur_x, n_cur_y, n_color, w_at_end};

    assign w_raw_x = {i_end_x[C-1], i_end_x} - {i_start_x[C-1], i_start_x};
    assign w_raw_y = {i_end_y[C-1], i_end_y} - {i_start_y[C-1], i_start_y};

    assign w_e2     = {r_err, 1'b0};
    assign w_ndy_e  = {{3{r_ndy[C]}}, r_ndy};
    assign w_dx_e   = {{3{r_dx[C]}}, r_dx};
    assign w_move_x = (w_e2 >= w_ndy_e);
    assign w_move_y = (w_e2 <= w_dx_e);

    always_comb begin
        n_cur_x  = r_cur_x;
        n_cur_y  = r_cur_y;
        n_tgt_x  = r_tgt_x;
        n_tgt_y  = r_tgt_y;
        n_dx     = r_dx;
        n_ndy    = r_ndy;
        n_sx_neg = r_sx_neg;
        n_sy_neg = r_sy_neg;
        n_err    = r_err;
        n_color  = r_color;
        if (w_start) begin
            n_cur_x  = i_start_x;
            n_cur_y  = i_start_y;
            n_tgt_x  = i_end_x;
            n_tgt_y  = i_end_y;
            n_dx     = w_raw_x[C] ? -w_raw_x : w_raw_x;
            n_ndy    = w_raw_y[C] ? w_raw_y : -w_raw_y;
            n_sx_neg = w_raw_x[C] | (w_raw_x == '0);
            n_sy_neg = w_raw_y[C] | (w_raw_y == '0);
            n_err    = {{2{n_dx[C]}}, n_dx} + {{2{n_ndy[C]}}, n_ndy};
            n_color  = i_pen_color;
        end else begin
            if (w_move_x) begin
                n_cur_x = r_sx_neg ? r_cur_x - 1'b1 : r_cur_x + 1'b1;
            end
            if (w_move_y) begin
                n_cur_y = r_sy_neg ? r_cur_y - 1'b1 : r_cur_y + 1'b1;
            end
            n_err = r_err + (w_move_x ? w_ndy_e[C+2:0] : '0)
                          + (w_move_y ? w_dx_e[C+2:0] : '0);
        end
        w_at_end = (n_cur_x == n_tgt_x) && (n_cur_y == n_tgt_y);
        n_active = ~w_at_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x  <= '0;
            r_cur_y  <= '0;
            r_tgt_x  <= '0;
            r_tgt_y  <= '0;
            r_dx     <= '0;
            r_ndy    <= '0;
            r_sx_neg <= 1'b0;
            r_sy_neg <= 1'b0;
            r_err    <= '0;
            r_color  <= '0;
            r_active <= 1'b0;
        end else if (o_q_push) begin
            // a step while idle leaves the state alone
            r_cur_x  <= n_cur_x;
            r_cur_y  <= n_cur_y;
            r_tgt_x  <= n_tgt_x;
            r_tgt_y  <= n_tgt_y;
            r_dx     <= n_dx;
            r_ndy    <= n_ndy;
            r_sx_neg <= n_sx_neg;
            r_sy_neg <= n_sy_neg;
            r_err    <= n_err;
            r_color  <= n_color;
            r_active <= n_active;
        end
    end

    `L2P_ASSERT(a_end_goes_idle, i_clk, i_rst_n, (o_q_push && w_at_end) |=> !r_active, "line end left stepper active")
    `L2P_ASSERT(a_idle_step_silent, i_clk, i_rst_n, (w_accept && !w_start && !r_active) |-> !o_q_push, "idle step produced a point")

endmodule

`default_nettype wire

@@ hw/rtl/l2p_back.sv @@
// Address unit: linear index multiply, frame check and output register.
`default_nettype none
`include "line_to_2bpp_pixel_writer_unit_defines.svh"

module l2p_back #(
    parameter int COORD_BITS = 12
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire l2p_pkg::t_cfg                i_cfg,
    input  wire logic                         i_q_valid,
    input  wire logic [2*COORD_BITS+l2p_pkg::COLOR_BITS:0] i_q_data,
    output logic                              o_q_pop,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic signed [COORD_BITS-1:0]      o_point_x,
    output logic signed [COORD_BITS-1:0]      o_point_y,
    output logic [l2p_pkg::WORD_BITS-1:0]     o_word_index,
    output logic [l2p_pkg::OFF_BITS-1:0]      o_bit_offset,
    output logic [l2p_pkg::COLOR_BITS-1:0]    o_pixel_value,
    output logic                              o_write_enable,
    output logic                              o_last
);

    localparam int C      = COORD_BITS;
    localparam int PROD_W = C + l2p_pkg::LW_BITS + 1;
    localparam int IDX_W  = PROD_W + 1;
    localparam int WRD_W  = IDX_W - 4;

    logic signed [C-1:0] w_q_x;
    logic signed [C-1:0] w_q_y;
    logic [l2p_pkg::COLOR_BITS-1:0] w_q_color;
    logic                w_q_last;

    logic                w_b_ready;
    logic                w_a_ready;

    // stage A: product y * line_width
    logic                r_a_valid;
    logic signed [PROD_W-1:0] r_a_prod;
    logic signed [C-1:0] r_a_x;
    logic signed [C-1:0] r_a_y;
    logic [l2p_pkg::COLOR_BITS-1:0] r_a_color;
    logic                r_a_last;

    // stage B: finished word
    logic                r_b_valid;
    logic signed [C-1:0] r_b_x;
    logic signed [C-1:0] r_b_y;
    logic [l2p_pkg::WORD_BITS-1:0] r_b_word;
    logic [l2p_pkg::OFF_BITS-1:0]  r_b_off;
    logic [l2p_pkg::COLOR_BITS-1:0] r_b_color;
    logic                r_b_we;
    logic                r_b_last;

    logic signed [IDX_W-1:0] w_idx;
    logic [WRD_W-1:0]    w_word;
    logic [l2p_pkg::FW_BITS-1:0] w_cap;
    logic                w_in_frame;

    assign {w_q_x, w_q_y, w_q_color, w_q_last} = i_q_data;

    assign w_b_ready = ~r_b_valid | ~i_stall;
    assign w_a_ready = ~r_a_valid | w_b_ready;
    assign o_q_pop   = i_q_valid & w_a_ready;

    assign w_idx  = {{(IDX_W-PROD_W){r_a_prod[PROD_W-1]}}, r_a_prod}
                  + {{(IDX_W-C){r_a_x[C-1]}}, r_a_x};
    assign w_word = w_idx[IDX_W-1:4];
    assign w_cap  = i_cfg.frame_words[l2p_pkg::FW_BITS-1] ? l2p_pkg::FRAME_CAP
                                                          : i_cfg.frame_words;
    assign w_in_frame = ~w_idx[IDX_W-1]
                      & (w_word < {{(WRD_W-l2p_pkg::FW_BITS){1'b0}}, w_cap});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (w_a_ready) begin
                r_a_valid <= i_q_valid;
            end
            if (w_b_ready) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_a_prod  <= PROD_W'(w_q_y) * PROD_W'($signed({1'b0, i_cfg.line_width}));
            r_a_x     <= w_q_x;
            r_a_y     <= w_q_y;
            r_a_color <= w_q_color;
            r_a_last  <= w_q_last;
        end
        if (w_b_ready && r_a_valid) begin
            r_b_x     <= r_a_x;
            r_b_y     <= r_a_y;
            r_b_word  <= w_in_frame ? w_word[l2p_pkg::WORD_BITS-1:0] : '0;
            // first pixel of a word sits in the top bits
            r_b_off   <= w_in_frame ? {~w_idx[3:0], 1'b0} : '0;
            r_b_color <= r_a_color;
            r_b_we    <= w_in_frame;
            r_b_last  <= r_a_last;
        end
    end

    assign o_valid        = r_b_valid;
    assign o_point_x      = r_b_x;
    assign o_point_y      = r_b_y;
    assign o_word_index   = r_b_word;
    assign o_bit_offset   = r_b_off;
    assign o_pixel_value  = r_b_color;
    assign o_write_enable = r_b_we;
    assign o_last         = r_b_last;

    `L2P_ASSERT(a_unwritten_zero, i_clk, i_rst_n,
        (r_b_valid && !r_b_we) |-> (r_b_word == '0 && r_b_off == '0),
        "unwritten pixel carries an address")
    `L2P_ASSERT(a_stage_a_holds, i_clk, i_rst_n,
        (r_a_valid && !w_b_ready) |=> r_a_valid,
        "stage A dropped a point under stall")

endmodule

`default_nettype wire

@@ hw/rtl/line_to_2bpp_pixel_writer_unit.sv @@
// Line pixel writer for a packed 2-bit-per-pixel framebuffer.
// Path: each point of an accepted command is written to the point queue,
//   then to the product stage, then to the output register.
// Throughput: one command per cycle while o_in_stall is low; the address multiply is pipelined.
// Reset (synchronous, active low): stepper idle, queue empty,
//   line_width = 640, frame_words = 19200.
`default_nettype none

module line_to_2bpp_pixel_writer_unit #(
    parameter int COORD_BITS = 12
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,

    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic                         i_cmd,
    input  wire logic signed [COORD_BITS-1:0] i_start_x,
    input  wire logic signed [COORD_BITS-1:0] i_start_y,
    input  wire logic signed [COORD_BITS-1:0] i_end_x,
    input  wire logic signed [COORD_BITS-1:0] i_end_y,
    input  wire logic [l2p_pkg::COLOR_BITS-1:0] i_pen_color,

    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic signed [COORD_BITS-1:0]      o_point_x,
    output logic signed [COORD_BITS-1:0]      o_point_y,
    output logic [l2p_pkg::WORD_BITS-1:0]     o_word_index,
    output logic [l2p_pkg::OFF_BITS-1:0]      o_bit_offset,
    output logic [l2p_pkg::COLOR_BITS-1:0]    o_pixel_value,
    output logic                              o_write_enable,
    output logic                              o_last,

    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [l2p_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  wire logic [l2p_pkg::FW_BITS-1:0]  i_cfg_data
);

    localparam int Q_W = 2 * COORD_BITS + l2p_pkg::COLOR_BITS + 1;

    l2p_pkg::t_cfg    r_cfg;
    logic             w_q_full;
    logic             w_q_push;
    logic [Q_W-1:0]   w_q_wdata;
    logic             w_q_valid;
    logic             w_q_pop;
    logic [Q_W-1:0]   w_q_rdata;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.line_width  <= l2p_pkg::LINE_WIDTH_RST;
            r_cfg.frame_words <= l2p_pkg::FRAME_WORDS_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                l2p_pkg::CFG_LINE_WIDTH: begin
                    r_cfg.line_width <= i_cfg_data[l2p_pkg::LW_BITS-1:0];
                end
                l2p_pkg::CFG_FRAME_WORDS: begin
                    r_cfg.frame_words <= i_cfg_data;
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    l2p_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_stall     (o_in_stall),
        .i_cmd       (i_cmd),
        .i_start_x   (i_start_x),
        .i_start_y   (i_start_y),
        .i_end_x     (i_end_x),
        .i_end_y     (i_end_y),
        .i_pen_color (i_pen_color),
        .i_q_full    (w_q_full),
        .o_q_push    (w_q_push),
        .o_q_data    (w_q_wdata)
    );

    l2p_fifo #(
        .WIDTH (Q_W),
        .DEPTH (2)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_q_wdata),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_rdata)
    );

    l2p_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_q_valid      (w_q_valid),
        .i_q_data       (w_q_rdata),
        .o_q_pop        (w_q_pop),
        .o_valid        (o_out_valid),
        .i_stall        (i_out_stall),
        .o_point_x      (o_point_x),
        .o_point_y      (o_point_y),
        .o_word_index   (o_word_index),
        .o_bit_offset   (o_bit_offset),
        .o_pixel_value  (o_pixel_value),
        .o_write_enable (o_write_enable),
        .o_last         (o_last)
    );

endmodule

`default_nettype wire
